@@ rtl/stack_memory_access_unit_macros.svh @@
// Assertion macros shared by the stack memory access unit RTL.
`ifndef STACK_MEMORY_ACCESS_UNIT_MACROS_SVH
`define STACK_MEMORY_ACCESS_UNIT_MACROS_SVH

// Check a consequence in the same cycle as its antecedent.
`define SMAU_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("smau same-cycle check failed");

// Check a consequence in the cycle after its antecedent.
`define SMAU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("smau next-cycle check failed");

`endif

@@ rtl/smau_pkg.sv @@
// Types and constants of the stack memory access unit.
`timescale 1ns / 1ps

package smau_pkg;

    localparam logic [3:0] OP_LOAD      = 4'd0;
    localparam logic [3:0] OP_STORE     = 4'd1;
    localparam logic [3:0] OP_PUSH      = 4'd2;
    localparam logic [3:0] OP_POP       = 4'd3;
    localparam logic [3:0] OP_PUSH_PC   = 4'd4;
    localparam logic [3:0] OP_FETCH     = 4'd5;
    localparam logic [3:0] OP_SET_PC    = 4'd6;
    localparam logic [3:0] OP_SET_SP    = 4'd7;
    localparam logic [3:0] OP_STEP_BACK = 4'd8;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_MEM   = 2'd1;
    localparam logic [1:0] ST_UNDER = 2'd2;
    localparam logic [1:0] ST_OVER  = 2'd3;

    localparam logic       REG_STACK_BASE  = 1'b0;
    localparam logic       REG_STACK_LIMIT = 1'b1;

    localparam logic [15:0] STACK_BASE_RST  = 16'd65008;
    localparam logic [15:0] STACK_LIMIT_RST = 16'd65520;

    localparam logic [16:0] INC_ONE   = 17'd1;
    localparam logic [16:0] WORD_STEP = 17'd2;
    localparam logic [16:0] INSN_STEP = 17'd4;

    typedef struct packed {
        logic        sub;
        logic [16:0] opa;
        logic [16:0] opb;
    } alu_req_t;

    typedef struct packed {
        logic [16:0] sum;
        logic        borrow;
    } alu_rsp_t;

endpackage

@@ rtl/smau_alu.sv @@
// Shared add/subtract unit with borrow for address and bound checks.
`timescale 1ns / 1ps

module smau_alu (
    input  smau_pkg::alu_req_t req,
    output smau_pkg::alu_rsp_t rsp
);

    logic [17:0] full;

    always_comb begin
        if (req.sub) begin
            full = {1'b0, req.opa} - {1'b0, req.opb};
        end else begin
            full = {1'b0, req.opa} + {1'b0, req.opb};
        end
        rsp.sum    = full[16:0];
        rsp.borrow = req.sub & full[17];
    end

endmodule

@@ rtl/stack_memory_access_unit.sv @@
// Stack memory access unit: byte memory, PC and SP of a 16-bit processor core.
// One operation is taken at a time on s_*; its result (data, status, PC, SP) is held
// in an output register on m_*, and the next operation may be taken while it waits.
// Memory is one byte wide and single ported, and all bound checks and pointer
// steps go through one shared 17-bit adder. A fetch reads four bytes at the PC;
// load, store, push and pop move two bytes. The unit is ready again at the edge
// that registers the result. A result still waiting in the output register holds
// the next one in its last step. After reset the memory is zeroed by a sweep over
// all 2^ADDR_BITS addresses during which no operation is taken.
`timescale 1ns / 1ps
`include "stack_memory_access_unit_macros.svh"

module stack_memory_access_unit #(
    parameter int ADDR_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wr_data,
    // operation stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // address[15:0], value[31:16]
    input  logic [3:0]  s_tuser,   // operation[3:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // data[31:0], status[33:32],
                                   // program_counter[49:34], stack_pointer[65:50]
);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_CALC   = 6'b000100,
        S_MEM    = 6'b001000,
        S_DRAIN  = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t                 state_reg;
    logic [ADDR_BITS-1:0]   clr_cnt_reg;
    logic [1:0]             step_reg;
    logic [1:0]             beat_reg;
    logic                   rd_pend_reg;
    logic                   flag_reg;
    logic [3:0]             op_reg;
    logic [15:0]            addr_reg;
    logic [15:0]            val_reg;
    logic [15:0]            wval_reg;
    logic [15:0]            ptr_reg;
    logic [16:0]            tmp_reg;
    logic [31:0]            data_reg;
    logic [1:0]             status_reg;
    logic [15:0]            pc_reg;
    logic [15:0]            sp_reg;
    logic [15:0]            base_reg;
    logic [15:0]            limit_reg;
    logic                   m_tvalid_reg;
    logic [71:0]            m_tdata_reg;

    logic [7:0]             mem [2**ADDR_BITS];
    logic [7:0]             mem_rdata_reg;
    logic [ADDR_BITS-1:0]   mem_idx;
    logic [7:0]             mem_wdata;
    logic                   mem_we;
    logic                   mem_re;
    logic                   op_write;
    logic                   last_beat;
    logic                   out_free;

    smau_pkg::alu_req_t     alu_req;
    smau_pkg::alu_rsp_t     alu_rsp;

    smau_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    assign op_write  = (op_reg == smau_pkg::OP_STORE) || (op_reg == smau_pkg::OP_PUSH)
                    || (op_reg == smau_pkg::OP_PUSH_PC);
    assign last_beat = (op_reg == smau_pkg::OP_FETCH) ? (beat_reg == 2'd3)
                                                      : (beat_reg == 2'd1);

    assign mem_we    = (state_reg == S_CLEAR) || ((state_reg == S_MEM) && op_write);
    assign mem_re    = (state_reg == S_MEM) && !op_write;
    assign mem_idx   = (state_reg == S_CLEAR) ? clr_cnt_reg : ptr_reg[ADDR_BITS-1:0];
    assign mem_wdata = (state_reg == S_CLEAR) ? 8'd0
                     : (beat_reg == 2'd0)     ? wval_reg[7:0] : wval_reg[15:8];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_idx] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_idx];
        end
    end

    always_comb begin
        alu_req = '0;
        case (state_reg)
            S_CALC: begin
                case (op_reg)
                    smau_pkg::OP_LOAD: begin
                        alu_req.sub = 1'b1;
                        if (step_reg == 2'd0) begin
                            alu_req.opa = {1'b0, base_reg};
                            alu_req.opb = {1'b0, addr_reg};
                        end else begin
                            alu_req.opa = {1'b0, addr_reg};
                            alu_req.opb = {1'b0, limit_reg};
                        end
                    end
                    smau_pkg::OP_STORE: begin
                        alu_req.sub = 1'b1;
                        alu_req.opa = {1'b0, base_reg};
                        alu_req.opb = {1'b0, addr_reg};
                    end
                    smau_pkg::OP_PUSH, smau_pkg::OP_PUSH_PC: begin
                        if (step_reg == 2'd0) begin
                            alu_req.opa = {1'b0, sp_reg};
                            alu_req.opb = smau_pkg::WORD_STEP;
                        end else begin
                            alu_req.sub = 1'b1;
                            alu_req.opa = {1'b0, limit_reg};
                            alu_req.opb = tmp_reg;
                        end
                    end
                    smau_pkg::OP_POP: begin
                        if (step_reg == 2'd0) begin
                            alu_req.opa = {1'b0, base_reg};
                            alu_req.opb = smau_pkg::WORD_STEP;
                        end else if (step_reg == 2'd1) begin
                            alu_req.sub = 1'b1;
                            alu_req.opa = {1'b0, sp_reg};
                            alu_req.opb = tmp_reg;
                        end else begin
                            alu_req.sub = 1'b1;
                            alu_req.opa = {1'b0, sp_reg};
                            alu_req.opb = smau_pkg::WORD_STEP;
                        end
                    end
                    smau_pkg::OP_SET_PC: begin
                        alu_req.sub = 1'b1;
                        alu_req.opa = {1'b0, base_reg};
                        alu_req.opb = {1'b0, val_reg};
                    end
                    smau_pkg::OP_SET_SP: begin
                        alu_req.sub = 1'b1;
                        if (step_reg == 2'd0) begin
                            alu_req.opa = {1'b0, val_reg};
                            alu_req.opb = {1'b0, base_reg};
                        end else begin
                            alu_req.opa = {1'b0, limit_reg};
                            alu_req.opb = {1'b0, val_reg};
                        end
                    end
                    smau_pkg::OP_STEP_BACK: begin
                        alu_req.sub = 1'b1;
                        alu_req.opa = {1'b0, pc_reg};
                        alu_req.opb = smau_pkg::INSN_STEP;
                    end
                    default: begin
                        alu_req = '0;
                    end
                endcase
            end
            S_MEM: begin
                alu_req.opa = {1'b0, ptr_reg};
                alu_req.opb = smau_pkg::INC_ONE;
            end
            default: begin
                alu_req = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            step_reg     <= 2'd0;
            beat_reg     <= 2'd0;
            rd_pend_reg  <= 1'b0;
            flag_reg     <= 1'b0;
            op_reg       <= 4'd0;
            addr_reg     <= 16'd0;
            val_reg      <= 16'd0;
            wval_reg     <= 16'd0;
            ptr_reg      <= 16'd0;
            tmp_reg      <= 17'd0;
            data_reg     <= 32'd0;
            status_reg   <= smau_pkg::ST_OK;
            pc_reg       <= 16'd0;
            sp_reg       <= 16'd0;
            base_reg     <= smau_pkg::STACK_BASE_RST;
            limit_reg    <= smau_pkg::STACK_LIMIT_RST;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= 72'd0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == smau_pkg::REG_STACK_BASE) begin
                    base_reg <= cfg_wr_data;
                end else begin
                    limit_reg <= cfg_wr_data;
                end
            end

            rd_pend_reg <= mem_re;
            if (rd_pend_reg) begin
                if (op_reg == smau_pkg::OP_FETCH) begin
                    data_reg <= {data_reg[23:0], mem_rdata_reg};
                end else begin
                    data_reg <= {16'd0, mem_rdata_reg, data_reg[15:8]};
                end
            end

            if (m_tvalid_reg && m_tready && !((state_reg == S_FINISH) && out_free)) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + ADDR_BITS'(1);
                    if (&clr_cnt_reg) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg     <= s_tuser;
                        addr_reg   <= s_tdata[15:0];
                        val_reg    <= s_tdata[31:16];
                        wval_reg   <= (s_tuser == smau_pkg::OP_PUSH_PC) ? pc_reg
                                                                        : s_tdata[31:16];
                        step_reg   <= 2'd0;
                        beat_reg   <= 2'd0;
                        data_reg   <= 32'd0;
                        status_reg <= smau_pkg::ST_OK;
                        if (s_tuser == smau_pkg::OP_FETCH) begin
                            ptr_reg   <= pc_reg;
                            state_reg <= S_MEM;
                        end else if ((s_tuser == smau_pkg::OP_PUSH)
                                  || (s_tuser == smau_pkg::OP_PUSH_PC)) begin
                            ptr_reg   <= sp_reg;
                            state_reg <= S_CALC;
                        end else begin
                            ptr_reg   <= s_tdata[15:0];
                            state_reg <= S_CALC;
                        end
                    end
                end
                S_CALC: begin
                    case (op_reg)
                        smau_pkg::OP_LOAD: begin
                            if (step_reg == 2'd0) begin
                                flag_reg <= alu_rsp.borrow;
                                step_reg <= 2'd1;
                            end else if (flag_reg && alu_rsp.borrow) begin
                                status_reg <= smau_pkg::ST_MEM;
                                state_reg  <= S_FINISH;
                            end else begin
                                state_reg <= S_MEM;
                            end
                        end
                        smau_pkg::OP_STORE: begin
                            if (alu_rsp.borrow) begin
                                status_reg <= smau_pkg::ST_MEM;
                                state_reg  <= S_FINISH;
                            end else begin
                                state_reg <= S_MEM;
                            end
                        end
                        smau_pkg::OP_PUSH, smau_pkg::OP_PUSH_PC: begin
                            if (step_reg == 2'd0) begin
                                tmp_reg  <= alu_rsp.sum;
                                step_reg <= 2'd1;
                            end else if (alu_rsp.borrow) begin
                                status_reg <= smau_pkg::ST_OVER;
                                state_reg  <= S_FINISH;
                            end else begin
                                sp_reg    <= tmp_reg[15:0];
                                state_reg <= S_MEM;
                            end
                        end
                        smau_pkg::OP_POP: begin
                            if (step_reg == 2'd0) begin
                                tmp_reg  <= alu_rsp.sum;
                                step_reg <= 2'd1;
                            end else if (step_reg == 2'd1) begin
                                if (alu_rsp.borrow) begin
                                    status_reg <= smau_pkg::ST_UNDER;
                                    state_reg  <= S_FINISH;
                                end else begin
                                    step_reg <= 2'd2;
                                end
                            end else begin
                                sp_reg    <= alu_rsp.sum[15:0];
                                ptr_reg   <= alu_rsp.sum[15:0];
                                state_reg <= S_MEM;
                            end
                        end
                        smau_pkg::OP_SET_PC: begin
                            if (alu_rsp.borrow) begin
                                status_reg <= smau_pkg::ST_MEM;
                            end else begin
                                pc_reg <= val_reg;
                            end
                            state_reg <= S_FINISH;
                        end
                        smau_pkg::OP_SET_SP: begin
                            if (step_reg == 2'd0) begin
                                flag_reg <= alu_rsp.borrow;
                                step_reg <= 2'd1;
                            end else begin
                                if (flag_reg || alu_rsp.borrow) begin
                                    status_reg <= smau_pkg::ST_MEM;
                                end else begin
                                    sp_reg <= val_reg;
                                end
                                state_reg <= S_FINISH;
                            end
                        end
                        smau_pkg::OP_STEP_BACK: begin
                            pc_reg    <= alu_rsp.sum[15:0];
                            state_reg <= S_FINISH;
                        end
                        default: begin
                            state_reg <= S_FINISH;
                        end
                    endcase
                end
                S_MEM: begin
                    ptr_reg  <= alu_rsp.sum[15:0];
                    beat_reg <= beat_reg + 2'd1;
                    if (last_beat) begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (op_reg == smau_pkg::OP_FETCH) begin
                        pc_reg <= ptr_reg;
                    end
                    state_reg <= S_FINISH;
                end
                S_FINISH: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {6'd0, sp_reg, pc_reg, status_reg, data_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `SMAU_ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `SMAU_ASSERT_SAME(a_no_write_when_idle, aclk, aresetn, state_reg == S_IDLE, !mem_we)
    `SMAU_ASSERT_NEXT(a_pc_held_when_idle, aclk, aresetn, state_reg == S_IDLE, $stable(pc_reg))

endmodule
